// ===== sv/svg_pkg.sv =====
// shared constants, types and tables for the uv-sphere vertex generator
// no dependencies; imported by every module of the block
`default_nettype none

package svg_pkg;

   localparam int MAX_DIVISIONS = 256;
   localparam int CORDIC_STAGES = 16;

   localparam int COUNT_W  = 9;
   localparam int INDEX_W  = 9;
   localparam int RADIUS_W = 16;
   localparam int VIDX_W   = 17;
   localparam int POS_W    = 17;
   localparam int NORM_W   = 16;
   localparam int ANGLE_W  = 32;
   localparam int CW       = 34;   // cordic datapath, q2.30 plus guard bits
   localparam int TRIG_W   = 32;   // sine and cosine after quadrant fixup
   localparam int PROD_W   = 2 * TRIG_W;
   localparam int RPROD_W  = RADIUS_W + 1 + TRIG_W;

   localparam int DIV_W      = 48;
   localparam int DIV_STEP   = 8;
   localparam int DIV_STAGES = DIV_W / DIV_STEP;

   localparam int BACK_LAT    = DIV_STAGES + CORDIC_STAGES + 6;
   localparam int SVG_LATENCY = BACK_LAT + 2;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STACK  = 2'd2;

   localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd256;
   localparam logic [COUNT_W-1:0]  COUNT_RST  = 9'd16;

   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef struct packed {
      logic [RADIUS_W-1:0] radius;
      logic [COUNT_W-1:0]  stack_cnt;   // effective counts, 1 to MAX_DIVISIONS
      logic [COUNT_W-1:0]  slice_cnt;
   } cfg_type;

   typedef struct packed {
      logic               oor;
      logic [VIDX_W-1:0]  vidx;
      logic [INDEX_W-1:0] stack;
      logic [INDEX_W-1:0] slice;
   } item_type;

   typedef struct packed {
      logic              valid;
      logic              oor;
      logic [VIDX_W-1:0] vidx;
   } tag_type;

   typedef struct packed {
      logic empty;
      logic afull;
   } fifo_stat_type;

   function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] c);
      logic [COUNT_W-1:0] r;
      if (c == '0)
         r = COUNT_W'(1);
      else if (c > COUNT_W'(MAX_DIVISIONS))
         r = COUNT_W'(MAX_DIVISIONS);
      else
         r = c;
      return r;
   endfunction

   // arctangent of 2^-i in turns, q0.32
   function automatic logic signed [CW-1:0] atan_turn(input int i);
      logic signed [CW-1:0] r;
      case (i)
         0:  r = 34'sd536870912;
         1:  r = 34'sd316933406;
         2:  r = 34'sd167458907;
         3:  r = 34'sd85004756;
         4:  r = 34'sd42667331;
         5:  r = 34'sd21354465;
         6:  r = 34'sd10679838;
         7:  r = 34'sd5340245;
         8:  r = 34'sd2670163;
         9:  r = 34'sd1335087;
         10: r = 34'sd667544;
         11: r = 34'sd333772;
         12: r = 34'sd166886;
         13: r = 34'sd83443;
         14: r = 34'sd41722;
         15: r = 34'sd20861;
         16: r = 34'sd10430;
         17: r = 34'sd5215;
         18: r = 34'sd2608;
         19: r = 34'sd1304;
         20: r = 34'sd652;
         21: r = 34'sd326;
         22: r = 34'sd163;
         23: r = 34'sd81;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/svg_front.sv =====
// front end: takes grid points, range-checks them and forms the flat vertex index
// depends on svg_pkg
`default_nettype none

module svg_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [svg_pkg::INDEX_W-1:0]  stack_index,
   input  logic [svg_pkg::INDEX_W-1:0]  slice_index,
   input  svg_pkg::cfg_type             cfg,
   input  svg_pkg::fifo_stat_type       fifo_stat,
   output logic                         push,
   output svg_pkg::item_type            push_item
);
   import svg_pkg::*;

   logic     item_valid_ff;
   item_type item_ff;
   item_type item_in;
   logic     accept;
   logic [COUNT_W:0]      slice_p1;
   logic [VIDX_W+2:0]     vidx_full;

   assign busy   = fifo_stat.afull;
   assign accept = start & ~busy;

   always_comb begin
      slice_p1      = {1'b0, cfg.slice_cnt} + (COUNT_W+1)'(1);
      vidx_full     = (VIDX_W+3)'(stack_index) * (VIDX_W+3)'(slice_p1)
                    + (VIDX_W+3)'(slice_index);
      item_in.stack = stack_index;
      item_in.slice = slice_index;
      item_in.oor   = (stack_index > cfg.stack_cnt) | (slice_index > cfg.slice_cnt);
      item_in.vidx  = item_in.oor ? '0 : vidx_full[VIDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= accept;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign push      = item_valid_ff;
   assign push_item = item_ff;

endmodule

`default_nettype wire

// ===== sv/svg_fifo.sv =====
// short queue between the front end and the back end
// depends on svg_pkg
`default_nettype none

module svg_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  svg_pkg::item_type      push_item,
   input  logic                   pop,
   output svg_pkg::item_type      pop_item,
   output svg_pkg::fifo_stat_type stat
);
   import svg_pkg::*;

   item_type             slot_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_AW:0]     count_ff;
   logic [FIFO_AW:0]     count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop)
         count_in = count_ff + (FIFO_AW+1)'(1);
      else if (!push && pop)
         count_in = count_ff - (FIFO_AW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         if (pop)
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item   = slot_ff[rd_ptr_ff];
   // one slot is kept free for the item held in the front register
   assign stat.empty = (count_ff == '0);
   assign stat.afull = (count_ff >= (FIFO_AW+1)'(FIFO_DEPTH - 1));

endmodule

`default_nettype wire

// ===== sv/svg_div.sv =====
// pipelined radix-2 divider, several quotient bits per stage, 9-bit divisor
// depends on svg_pkg
`default_nettype none

module svg_div (
   input  logic                        clock,
   input  logic [svg_pkg::DIV_W-1:0]   dividend,
   input  logic [svg_pkg::COUNT_W-1:0] divisor,
   output logic [svg_pkg::ANGLE_W-1:0] quotient
);
   import svg_pkg::*;

   logic [COUNT_W-1:0] rem_ff [DIV_STAGES];
   logic [DIV_W-1:0]   num_ff [DIV_STAGES];
   logic [ANGLE_W-1:0] quo_ff [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [COUNT_W-1:0] rem_src, rem_in;
      logic [DIV_W-1:0]   num_src, num_in;
      logic [ANGLE_W-1:0] quo_src, quo_in;
      logic [COUNT_W:0]   trial;

      if (s == 0) begin : g_first
         assign rem_src = '0;
         assign num_src = dividend;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign num_src = num_ff[s-1];
         assign quo_src = quo_ff[s-1];
      end

      always_comb begin
         rem_in = rem_src;
         num_in = num_src;
         quo_in = quo_src;
         trial  = '0;
         for (int j = 0; j < DIV_STEP; j++) begin
            trial  = {rem_in, num_in[DIV_W-1]};
            num_in = {num_in[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
               trial  = trial - {1'b0, divisor};
               quo_in = {quo_in[ANGLE_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_in[ANGLE_W-2:0], 1'b0};
            end
            rem_in = trial[COUNT_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s] <= rem_in;
         num_ff[s] <= num_in;
         quo_ff[s] <= quo_in;
      end
   end

   assign quotient = quo_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== sv/svg_cordic.sv =====
// pipelined rotation-mode cordic: angle in turns to cosine and sine, q2.30
// depends on svg_pkg
`default_nettype none

module svg_cordic (
   input  logic                               clock,
   input  logic [svg_pkg::ANGLE_W-1:0]        angle,
   output logic signed [svg_pkg::TRIG_W-1:0]  cos_out,
   output logic signed [svg_pkg::TRIG_W-1:0]  sin_out
);
   import svg_pkg::*;

   logic signed [CW-1:0] x_ff [CORDIC_STAGES+1];
   logic signed [CW-1:0] y_ff [CORDIC_STAGES+1];
   logic signed [CW-1:0] z_ff [CORDIC_STAGES+1];
   logic [1:0]           q_ff [CORDIC_STAGES+1];
   logic signed [TRIG_W-1:0] cos_ff, sin_ff;

   logic [ANGLE_W-1:0] rnd_in, res_in;
   logic [1:0]         q_in;

   // reduce to the nearest quarter turn, residual in [-1/8, 1/8)
   always_comb begin
      rnd_in = angle + ANGLE_W'(32'h2000_0000);
      q_in   = rnd_in[ANGLE_W-1:ANGLE_W-2];
      res_in = angle - {q_in, {(ANGLE_W-2){1'b0}}};
   end

   always_ff @(posedge clock) begin
      x_ff[0] <= CORDIC_GAIN;
      y_ff[0] <= '0;
      z_ff[0] <= CW'(signed'(res_in));
      q_ff[0] <= q_in;
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
      logic signed [CW-1:0] dx, dy;
      assign dx = x_ff[i] >>> i;
      assign dy = y_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (!z_ff[i][CW-1]) begin
            x_ff[i+1] <= x_ff[i] - dy;
            y_ff[i+1] <= y_ff[i] + dx;
            z_ff[i+1] <= z_ff[i] - atan_turn(i);
         end else begin
            x_ff[i+1] <= x_ff[i] + dy;
            y_ff[i+1] <= y_ff[i] - dx;
            z_ff[i+1] <= z_ff[i] + atan_turn(i);
         end
         q_ff[i+1] <= q_ff[i];
      end
   end

   logic signed [CW-1:0] xl, yl, nx, ny;
   logic signed [TRIG_W-1:0] cos_in, sin_in;

   always_comb begin
      xl = x_ff[CORDIC_STAGES];
      yl = y_ff[CORDIC_STAGES];
      nx = -xl;
      ny = -yl;
      case (q_ff[CORDIC_STAGES])
         2'd0:    begin cos_in = xl[TRIG_W-1:0]; sin_in = yl[TRIG_W-1:0]; end
         2'd1:    begin cos_in = ny[TRIG_W-1:0]; sin_in = xl[TRIG_W-1:0]; end
         2'd2:    begin cos_in = nx[TRIG_W-1:0]; sin_in = ny[TRIG_W-1:0]; end
         default: begin cos_in = yl[TRIG_W-1:0]; sin_in = nx[TRIG_W-1:0]; end
      endcase
   end

   always_ff @(posedge clock) begin
      cos_ff <= cos_in;
      sin_ff <= sin_in;
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

`default_nettype wire

// ===== sv/svg_back.sv =====
// back end: angle division, sine/cosine, products, rounding and saturation
// depends on svg_pkg, svg_div, svg_cordic
`default_nettype none

module svg_back (
   input  logic                               clock,
   input  logic                               reset,
   input  svg_pkg::cfg_type                   cfg,
   input  svg_pkg::fifo_stat_type             fifo_stat,
   input  svg_pkg::item_type                  item,
   output logic                               pop,
   output logic                               rsp_valid,
   output logic [svg_pkg::VIDX_W-1:0]         rsp_vertex_index,
   output logic signed [svg_pkg::POS_W-1:0]   rsp_pos_x,
   output logic signed [svg_pkg::POS_W-1:0]   rsp_pos_y,
   output logic signed [svg_pkg::POS_W-1:0]   rsp_pos_z,
   output logic signed [svg_pkg::NORM_W-1:0]  rsp_normal_x,
   output logic signed [svg_pkg::NORM_W-1:0]  rsp_normal_y,
   output logic signed [svg_pkg::NORM_W-1:0]  rsp_normal_z,
   output logic                               rsp_out_of_range
);
   import svg_pkg::*;

   localparam logic signed [PROD_W-1:0]  HALF_P = PROD_W'(64'sd536870912);
   localparam logic signed [RPROD_W-1:0] HALF_R = RPROD_W'(64'sd536870912);
   localparam logic signed [TRIG_W-1:0]  HALF_N = TRIG_W'(32'sd16384);
   localparam logic signed [RPROD_W-1:0] POS_MAX = RPROD_W'(64'sd65535);
   localparam logic signed [TRIG_W-1:0]  N_MAX = TRIG_W'(32'sd32767);
   localparam logic signed [TRIG_W-1:0]  N_MIN = -TRIG_W'(32'sd32768);

   // back end never stalls
   assign pop = ~fifo_stat.empty;

   logic [ANGLE_W-1:0] lat_angle, lon_angle;

   svg_div u_div_lat (
      .clock    (clock),
      .dividend (DIV_W'({item.stack, 31'b0})),
      .divisor  (cfg.stack_cnt),
      .quotient (lat_angle)
   );

   svg_div u_div_lon (
      .clock    (clock),
      .dividend (DIV_W'({item.slice, 32'b0})),
      .divisor  (cfg.slice_cnt),
      .quotient (lon_angle)
   );

   logic signed [TRIG_W-1:0] cp, sp, ct, st;

   svg_cordic u_cordic_lat (
      .clock   (clock),
      .angle   (lat_angle),
      .cos_out (cp),
      .sin_out (sp)
   );

   svg_cordic u_cordic_lon (
      .clock   (clock),
      .angle   (lon_angle),
      .cos_out (ct),
      .sin_out (st)
   );

   // unit vector products
   logic signed [PROD_W-1:0] px_ff, pz_ff;
   logic signed [TRIG_W-1:0] cp_ff;
   logic signed [TRIG_W-1:0] u_ff [3];
   logic signed [RPROD_W-1:0] r_ff [3];
   logic signed [TRIG_W-1:0] ud_ff [3];
   logic signed [POS_W-1:0]  pos_ff [3];
   logic signed [NORM_W-1:0] nrm_ff [3];
   logic signed [PROD_W-1:0] ux_in, uz_in;
   logic signed [RADIUS_W:0] rad_s;

   assign rad_s = signed'({1'b0, cfg.radius});
   assign ux_in = (px_ff + HALF_P) >>> 30;
   assign uz_in = (pz_ff + HALF_P) >>> 30;

   always_ff @(posedge clock) begin
      px_ff   <= sp * ct;
      pz_ff   <= sp * st;
      cp_ff   <= cp;
      u_ff[0] <= ux_in[TRIG_W-1:0];
      u_ff[1] <= cp_ff;
      u_ff[2] <= uz_in[TRIG_W-1:0];
   end

   for (genvar k = 0; k < 3; k++) begin : g_comp
      logic signed [RPROD_W-1:0] pr;
      logic signed [TRIG_W-1:0]  nr;
      logic signed [POS_W-1:0]   pos_in;
      logic signed [NORM_W-1:0]  nrm_in;

      always_comb begin
         pr = (r_ff[k] + HALF_R) >>> 30;
         nr = (ud_ff[k] + HALF_N) >>> 15;
         if (pr > POS_MAX)
            pos_in = POS_W'(17'sd65535);
         else if (pr < -POS_MAX)
            pos_in = -POS_W'(17'sd65535);
         else
            pos_in = pr[POS_W-1:0];
         if (nr > N_MAX)
            nrm_in = N_MAX[NORM_W-1:0];
         else if (nr < N_MIN)
            nrm_in = N_MIN[NORM_W-1:0];
         else
            nrm_in = nr[NORM_W-1:0];
      end

      always_ff @(posedge clock) begin
         r_ff[k]   <= rad_s * u_ff[k];
         ud_ff[k]  <= u_ff[k];
         pos_ff[k] <= pos_in;
         nrm_ff[k] <= nrm_in;
      end
   end

   // item tags run alongside the datapath
   tag_type tag_ff [BACK_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BACK_LAT; i++)
            tag_ff[i] <= '0;
      end else begin
         tag_ff[0] <= '{valid: pop, oor: item.oor, vidx: item.vidx};
         for (int i = 1; i < BACK_LAT; i++)
            tag_ff[i] <= tag_ff[i-1];
      end
   end

   logic oor;
   assign oor = tag_ff[BACK_LAT-1].oor;

   assign rsp_valid        = tag_ff[BACK_LAT-1].valid;
   assign rsp_out_of_range = oor;
   assign rsp_vertex_index = tag_ff[BACK_LAT-1].vidx;
   assign rsp_pos_x        = oor ? '0 : pos_ff[0];
   assign rsp_pos_y        = oor ? '0 : pos_ff[1];
   assign rsp_pos_z        = oor ? '0 : pos_ff[2];
   assign rsp_normal_x     = oor ? '0 : nrm_ff[0];
   assign rsp_normal_y     = oor ? '0 : nrm_ff[1];
   assign rsp_normal_z     = oor ? '0 : nrm_ff[2];

endmodule

`default_nettype wire

// ===== sv/sphere_vertex_generator_unit.sv =====
// top level of the uv-sphere vertex generator: csr registers, front, queue, back
// depends on svg_pkg, svg_front, svg_fifo, svg_back
`default_nettype none

// usage
//   request: a grid point (req_stack_index, req_slice_index) is taken at a rising
//   edge with start high and busy low. a new point may follow every cycle.
//   response: one vertex per point, in order, shown for exactly one cycle while
//   rsp_valid is high. the receiver cannot hold it off and needs no handshake.
//   path: from transfer to rsp_valid a point passes, with the default
//   16 cordic stages, the front register, queue, 6 divider stages, cordic
//   (quadrant stage, one stage per iteration, fixup stage), 3 product stages
//   and the output register. throughput is one vertex per cycle.
//   busy rises only if the queue fills, which does not happen in steady state
//   since the back end drains one item every cycle.
//   csr: csr_index 0 radius (q8.8), 1 slice_count, 2 stack_count; a transfer
//   takes place when csr_valid and csr_ready are high. csr_ready is always
//   high. write only while no points are in flight. other indexes are ignored.
//   reset: synchronous; clears the queue and the pipeline tags and loads
//   radius 1.0 and 16 divisions on each axis. no clearing pass is needed.
//   grid points beyond their count give out_of_range and zeros elsewhere.

module sphere_vertex_generator_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [svg_pkg::INDEX_W-1:0]         req_stack_index,
   input  logic [svg_pkg::INDEX_W-1:0]         req_slice_index,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [svg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [svg_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                rsp_valid,
   output logic [svg_pkg::VIDX_W-1:0]          rsp_vertex_index,
   output logic signed [svg_pkg::POS_W-1:0]    rsp_pos_x,
   output logic signed [svg_pkg::POS_W-1:0]    rsp_pos_y,
   output logic signed [svg_pkg::POS_W-1:0]    rsp_pos_z,
   output logic signed [svg_pkg::NORM_W-1:0]   rsp_normal_x,
   output logic signed [svg_pkg::NORM_W-1:0]   rsp_normal_y,
   output logic signed [svg_pkg::NORM_W-1:0]   rsp_normal_z,
   output logic                                rsp_out_of_range
);
   import svg_pkg::*;

   logic [RADIUS_W-1:0] radius_ff;
   logic [COUNT_W-1:0]  slice_cnt_ff;
   logic [COUNT_W-1:0]  stack_cnt_ff;
   logic                csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= RADIUS_RST;
         slice_cnt_ff <= COUNT_RST;
         stack_cnt_ff <= COUNT_RST;
      end else if (csr_wr) begin
         unique case (csr_index)
            CSR_RADIUS: radius_ff    <= csr_wdata;
            CSR_SLICE:  slice_cnt_ff <= csr_wdata[COUNT_W-1:0];
            CSR_STACK:  stack_cnt_ff <= csr_wdata[COUNT_W-1:0];
            default:    ;
         endcase
      end
   end

   // counts of zero act as one, counts above the limit are clamped
   cfg_type cfg;
   assign cfg.radius    = radius_ff;
   assign cfg.stack_cnt = eff_count(stack_cnt_ff);
   assign cfg.slice_cnt = eff_count(slice_cnt_ff);

   fifo_stat_type fifo_stat;
   item_type      push_item, pop_item;
   logic          push, pop;

   svg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .stack_index (req_stack_index),
      .slice_index (req_slice_index),
      .cfg         (cfg),
      .fifo_stat   (fifo_stat),
      .push        (push),
      .push_item   (push_item)
   );

   svg_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .stat      (fifo_stat)
   );

   svg_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .fifo_stat        (fifo_stat),
      .item             (pop_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pos_z        (rsp_pos_z),
      .rsp_normal_x     (rsp_normal_x),
      .rsp_normal_y     (rsp_normal_y),
      .rsp_normal_z     (rsp_normal_z),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

`default_nettype wire

// ===== sv/svg_checker.sv =====
// port-level checker for the vertex generator, bound to the top level
// depends on svg_pkg and sphere_vertex_generator_unit
`default_nettype none

module svg_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_valid,
   input logic [svg_pkg::VIDX_W-1:0]          rsp_vertex_index,
   input logic signed [svg_pkg::POS_W-1:0]    rsp_pos_x,
   input logic signed [svg_pkg::NORM_W-1:0]   rsp_normal_y,
   input logic                                rsp_out_of_range
);
   import svg_pkg::*;

   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_valid && !busy)
      else $error("pipeline not clear after reset");

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##SVG_LATENCY rsp_valid)
      else $error("response missing after transfer");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, SVG_LATENCY))
      else $error("response without a request");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |->
         (rsp_vertex_index == '0 && rsp_pos_x == '0 && rsp_normal_y == '0))
      else $error("out of range vertex carries data");

endmodule

bind sphere_vertex_generator_unit svg_checker u_svg_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_vertex_index (rsp_vertex_index),
   .rsp_pos_x        (rsp_pos_x),
   .rsp_normal_y     (rsp_normal_y),
   .rsp_out_of_range (rsp_out_of_range)
);

`default_nettype wire

// ===== verif/sphere_vertex_generator_unit_tb.sv =====
// self-checking bench for the uv-sphere vertex generator: driver, monitor, vertex predictor
// depends on svg_pkg and sphere_vertex_generator_unit
`default_nettype none

module sphere_vertex_generator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import svg_pkg::*;

   typedef struct {
      logic [VIDX_W-1:0]        vidx;
      logic signed [POS_W-1:0]  px, py, pz;
      logic signed [NORM_W-1:0] nx, ny, nz;
      logic                     oor;
   } vertex_type;

   typedef struct {
      logic [INDEX_W-1:0] stack;
      logic [INDEX_W-1:0] slice;
   } point_type;

   // angular steps in turns, q0.32, same values the hardware holds
   localparam longint ATAN_STEP [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [INDEX_W-1:0] req_stack_index = '0;
   logic [INDEX_W-1:0] req_slice_index = '0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic rsp_valid;
   logic [VIDX_W-1:0] rsp_vertex_index;
   logic signed [POS_W-1:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [NORM_W-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic rsp_out_of_range;

   // predictor copy of the registers
   logic [RADIUS_W-1:0] mdl_radius = 16'd256;
   logic [COUNT_W-1:0]  mdl_slices = 9'd16;
   logic [COUNT_W-1:0]  mdl_stacks = 9'd16;

   point_type  pending_points[$];
   vertex_type expected_vertices[$];
   int  fail_count = 0;
   int  sender_idle_pct = 0;

   sphere_vertex_generator_unit dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_half_up(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint eff_divs(logic [COUNT_W-1:0] c);
      if (c == 0) return 1;
      return c > MAX_DIVISIONS ? MAX_DIVISIONS : longint'(c);
   endfunction

   // cordic rotation of an angle in turns, results q2.30
   task automatic turn_sincos(input longint unsigned ang, output longint c,
                              output longint s);
      longint unsigned q, d;
      longint z, x, y, dx, dy;
      q = ((ang + 64'h2000_0000) >> 30) & 3;
      d = (ang - q * 64'h4000_0000) & 64'hFFFF_FFFF;
      z = d >= 64'h8000_0000 ? longint'(d) - 64'sh1_0000_0000 : longint'(d);
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN_STEP[i];
         end else begin
            x += dx; y -= dy; z += ATAN_STEP[i];
         end
      end
      case (q)
         0: begin c = x;  s = y;  end
         1: begin c = -y; s = x;  end
         2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endtask

   task automatic predict_vertex(input point_type p, output vertex_type v);
      longint sc, lc, cp, sp, ct, st, pos, nrm;
      longint unsigned lat, lon;
      longint u[3];
      sc = eff_divs(mdl_stacks);
      lc = eff_divs(mdl_slices);
      v = '{default: '0};
      if (p.stack > sc || p.slice > lc) begin
         v.oor = 1'b1;
         return;
      end
      lat = (longint'(p.stack) << 31) / sc;
      lon = ((longint'(p.slice) << 32) / lc) & 64'hFFFF_FFFF;
      turn_sincos(lat, cp, sp);
      turn_sincos(lon, ct, st);
      u[0] = round_half_up(sp * ct, 30);
      u[1] = cp;
      u[2] = round_half_up(sp * st, 30);
      v.vidx = VIDX_W'(p.stack * (lc + 1) + p.slice);
      for (int k = 0; k < 3; k++) begin
         pos = clamp(round_half_up(longint'(mdl_radius) * u[k], 30), -65535, 65535);
         nrm = clamp(round_half_up(u[k], 15), -32768, 32767);
         case (k)
            0: begin v.px = POS_W'(pos); v.nx = NORM_W'(nrm); end
            1: begin v.py = POS_W'(pos); v.ny = NORM_W'(nrm); end
            default: begin v.pz = POS_W'(pos); v.nz = NORM_W'(nrm); end
         endcase
      end
   endtask

   // capture whether the last rising edge moved a point
   always @(posedge clock) begin
      point_type p;
      vertex_type v;
      if (!reset && start && !busy) begin
         p = pending_points.pop_front();
         predict_vertex(p, v);
         expected_vertices.push_back(v);
      end
   end

   // driver: one grid point per transfer, random idle cycles on the sender side
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (pending_points.size() != 0 &&
                   ($urandom_range(99) >= sender_idle_pct)) begin
         start <= 1'b1;
         req_stack_index <= pending_points[0].stack;
         req_slice_index <= pending_points[0].slice;
      end else begin
         start <= 1'b0;
         req_stack_index <= INDEX_W'($urandom);
         req_slice_index <= INDEX_W'($urandom);
      end
   end

   // monitor: compare each vertex with the oldest prediction
   always @(posedge clock) begin
      vertex_type e;
      if (!reset && rsp_valid) begin
         if (expected_vertices.size() == 0) begin
            $error("vertex with no prediction waiting");
            fail_count++;
         end else begin
            e = expected_vertices.pop_front();
            if (rsp_vertex_index !== e.vidx) begin
               $error("vertex_index exp %0d got %0d", e.vidx, rsp_vertex_index);
               fail_count++;
            end
            if (rsp_pos_x !== e.px) begin
               $error("pos_x exp %0d got %0d", e.px, rsp_pos_x); fail_count++;
            end
            if (rsp_pos_y !== e.py) begin
               $error("pos_y exp %0d got %0d", e.py, rsp_pos_y); fail_count++;
            end
            if (rsp_pos_z !== e.pz) begin
               $error("pos_z exp %0d got %0d", e.pz, rsp_pos_z); fail_count++;
            end
            if (rsp_normal_x !== e.nx) begin
               $error("normal_x exp %0d got %0d", e.nx, rsp_normal_x); fail_count++;
            end
            if (rsp_normal_y !== e.ny) begin
               $error("normal_y exp %0d got %0d", e.ny, rsp_normal_y); fail_count++;
            end
            if (rsp_normal_z !== e.nz) begin
               $error("normal_z exp %0d got %0d", e.nz, rsp_normal_z); fail_count++;
            end
            if (rsp_out_of_range !== e.oor) begin
               $error("out_of_range exp %0d got %0d", e.oor, rsp_out_of_range);
               fail_count++;
            end
         end
      end
   end

   // wait until every queued point is taken and every vertex is back
   task automatic drain_all();
      while (pending_points.size() != 0 || expected_vertices.size() != 0)
         @(posedge clock);
      repeat (SVG_LATENCY + 4) @(posedge clock);
   endtask

   // register write at the falling edge, held until the transfer
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_RADIUS: mdl_radius = val;
         CSR_SLICE:  mdl_slices = val[COUNT_W-1:0];
         CSR_STACK:  mdl_stacks = val[COUNT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_point(input int st, input int sl);
      point_type p;
      p.stack = INDEX_W'(st);
      p.slice = INDEX_W'(sl);
      pending_points.push_back(p);
   endtask

   // mostly in-grid points, some just past the edge, a few anywhere
   task automatic add_random_points(input int n);
      int sc, lc, r;
      sc = eff_divs(mdl_stacks);
      lc = eff_divs(mdl_slices);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 80)
            add_point($urandom_range(sc), $urandom_range(lc));
         else if (r < 90)
            add_point(sc + 1, $urandom_range(lc));
         else
            add_point($urandom_range(511), $urandom_range(511));
      end
   endtask

   initial begin
      int idle_mix [4] = '{0, 64, 0, 13};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: poles, seams, edges of the grid and points past it
      add_point(0, 0);
      add_point(16, 16);
      add_point(8, 0);
      add_point(8, 4);
      add_point(8, 8);
      add_point(8, 12);
      add_point(4, 2);
      add_point(17, 0);
      add_point(0, 17);
      add_point(511, 511);
      add_point(256, 256);
      drain_all();

      // count of zero acts as one, huge radius saturates positions
      write_csr(CSR_RADIUS, 16'hFFFF);
      write_csr(CSR_SLICE, 16'd0);
      write_csr(CSR_STACK, 16'd0);
      add_point(0, 0);
      add_point(1, 1);
      add_point(1, 0);
      add_point(2, 0);
      drain_all();

      // counts above the maximum clamp to it
      write_csr(CSR_SLICE, 16'h01FF);
      write_csr(CSR_STACK, 16'h01FF);
      write_csr(CSR_RADIUS, 16'd0);
      add_point(256, 256);
      add_point(128, 64);
      add_point(257, 0);
      add_point(0, 257);
      drain_all();

      // random phases across several register settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin write_csr(CSR_RADIUS, 16'd256); write_csr(CSR_SLICE, 16'd16);
               write_csr(CSR_STACK, 16'd16); end
            1: begin write_csr(CSR_RADIUS, 16'hFFFF); write_csr(CSR_SLICE, 16'd256);
               write_csr(CSR_STACK, 16'd256); end
            2: begin write_csr(CSR_RADIUS, 16'd1); write_csr(CSR_SLICE, 16'd1);
               write_csr(CSR_STACK, 16'd1); end
            default: begin
               write_csr(CSR_RADIUS, CSR_DATA_W'($urandom));
               write_csr(CSR_SLICE, CSR_DATA_W'($urandom_range(511)));
               write_csr(CSR_STACK, CSR_DATA_W'($urandom_range(511)));
            end
         endcase
         sender_idle_pct = idle_mix[ph % 4];
         add_random_points(105);
         drain_all();
      end

      if (fail_count == 0)
         $display("sphere_vertex_generator_unit regression: pass");
      else
         $display("sphere_vertex_generator_unit regression: fail");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("sphere_vertex_generator_unit regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
